[rtl/blvd_pkg.sv]
// Shared types and codes for the bounded list with value delete.
`default_nettype none

package blvd_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned REQ_W     = 3;
  localparam int unsigned CNT_OUT_W = 5;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REM_FRONT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REM_BACK  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REM_VALUE = 3'd4;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Result handed from the controller to the output stage
  typedef struct packed {
    logic                 valid;
    status_e              status;
    logic [CNT_OUT_W-1:0] count;
  } res_t;

endpackage

`default_nettype wire

[rtl/bounded_list_with_value_delete_unit.sv]
// Top level of the bounded list with value delete: RAM, sequencer and output register.
//
//   channel | direction | valid       | stall       | payload
//   --------+-----------+-------------+-------------+------------------------------
//   in      | input     | in_valid_i  | in_stall_o  | req_type_i, item_value_i
//   out     | output    | out_valid_o | out_stall_i | status_o, entry_count_o
//
// Inserts and front/back removes finish in the cycle the transaction is
// accepted. Remove by value checks the front entry, then the back entry, then
// scans the middle entries and moves the later entries down to close the gap;
// a miss in a one-entry list ends after the front check. One RAM read per
// cycle sets the pace of the search and of the gap closing. One input
// transaction is taken while the previous result waits in the output register;
// the sequencer then holds until the register frees up. Reset clears count,
// front pointer and state; the RAM keeps its contents and needs no clearing pass.
`default_nettype none

module bounded_list_with_value_delete_unit
  import blvd_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [REQ_W-1:0]         req_type_i,
  input  wire logic signed [DATA_W-1:0] item_value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [1:0]                    status_o,
  output logic [CNT_OUT_W-1:0]          entry_count_o
);

  localparam int unsigned IW = $clog2(DEPTH);

  res_t              res;
  logic              res_free;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [IW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  logic                 out_valid_q;
  status_e              status_q;
  logic [CNT_OUT_W-1:0] count_q;

  // value storage, circular from the front pointer
  blvd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  blvd_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .item_value_i (item_value_i),
    .res_free_i   (res_free),
    .res_o        (res),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  // Output register frees when empty or when its transaction completes.
  assign res_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_free) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_free && res.valid) begin
      status_q <= res.status;
      count_q  <= res.count;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_count_o = count_q;

  // A result that could not be delivered keeps the input side stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && !res_free |=> in_stall_o)
    else $error("input accepted while a result is pending");

  // A produced result always lands in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && res_free |=> out_valid_o)
    else $error("result lost on its way to the output register");

  // Full is only reported with the list at capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> (entry_count_o == CNT_OUT_W'(DEPTH)))
    else $error("full status with a count below capacity");

  // Empty is only reported with nothing stored.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> (entry_count_o == '0))
    else $error("empty status with a nonzero count");

endmodule

`default_nettype wire

[rtl/blvd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module blvd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/blvd_ctrl.sv]
// Request sequencer: list pointers, value search and gap closing over the RAM.
`default_nettype none

module blvd_ctrl
  import blvd_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [REQ_W-1:0]         req_type_i,
  input  wire logic [DATA_W-1:0]        item_value_i,
  input  wire logic                     res_free_i,
  output res_t                          res_o,
  output logic                          mem_we_o,
  output logic [$clog2(DEPTH)-1:0]      mem_waddr_o,
  output logic [DATA_W-1:0]             mem_wdata_o,
  output logic [$clog2(DEPTH)-1:0]      mem_raddr_o,
  input  wire logic [DATA_W-1:0]        mem_rdata_i
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = CW + CNT_OUT_W;
  localparam logic [IW:0]   DEPTH_S = (IW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [IW-1:0] LAST_IX = IW'(DEPTH - 1);

  typedef enum logic [2:0] {
    IDLE,
    CHK_FRONT,
    CHK_BACK,
    SCAN,
    SHIFT,
    HOLD
  } state_e;

  state_e          state_q, state_d;
  logic [IW-1:0]   front_q, front_d;
  logic [CW-1:0]   count_q, count_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [IW-1:0]   k_q, k_d;
  status_e         pend_q, pend_d;

  logic            fin;
  status_e         fin_status;
  logic [IW-1:0]   front_inc, front_dec;
  logic [CW-1:0]   cnt_dec, cnt_inc;
  logic [CW:0]     k_p2;
  logic            hit;
  logic [EW-1:0]   cnt_ext;

  // Physical slot of logical entry k; base + k stays below twice the depth.
  function automatic logic [IW-1:0] slot(input logic [IW-1:0] base, input logic [IW-1:0] k);
    logic [IW:0] s;
    s = {1'b0, base} + {1'b0, k};
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[IW-1:0];
  endfunction

  assign front_inc = (front_q == LAST_IX) ? '0 : front_q + IW'(1);
  assign front_dec = (front_q == '0) ? LAST_IX : front_q - IW'(1);
  assign cnt_dec   = count_q - CW'(1);
  assign cnt_inc   = count_q + CW'(1);
  assign k_p2      = (CW + 1)'(k_q) + (CW + 1)'(2);
  assign hit       = (mem_rdata_i == val_q);

  assign in_stall_o = (state_q != IDLE);

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    val_d       = val_q;
    k_d         = k_q;
    pend_d      = pend_q;
    fin         = 1'b0;
    fin_status  = ST_DONE;
    mem_we_o    = 1'b0;
    mem_waddr_o = front_dec;
    mem_wdata_o = item_value_i;
    mem_raddr_o = front_q;

    unique case (state_q)
      IDLE: begin
        if (in_valid_i) begin
          unique case (req_type_i)
            REQ_INS_FRONT: begin
              fin = 1'b1;
              if (count_q == DEPTH_C) begin
                fin_status = ST_FULL;
              end else begin
                mem_we_o = 1'b1;
                front_d  = front_dec;
                count_d  = cnt_inc;
              end
            end
            REQ_INS_BACK: begin
              fin = 1'b1;
              if (count_q == DEPTH_C) begin
                fin_status = ST_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = slot(front_q, count_q[IW-1:0]);
                count_d     = cnt_inc;
              end
            end
            REQ_REM_FRONT: begin
              fin = 1'b1;
              if (count_q == '0) begin
                fin_status = ST_EMPTY;
              end else begin
                front_d = front_inc;
                count_d = cnt_dec;
              end
            end
            REQ_REM_BACK: begin
              fin = 1'b1;
              if (count_q == '0) begin
                fin_status = ST_EMPTY;
              end else begin
                count_d = cnt_dec;
              end
            end
            REQ_REM_VALUE: begin
              if (count_q == '0) begin
                fin        = 1'b1;
                fin_status = ST_EMPTY;
              end else begin
                val_d   = item_value_i;
                state_d = CHK_FRONT;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      CHK_FRONT: begin
        if (hit) begin
          fin     = 1'b1;
          front_d = front_inc;
          count_d = cnt_dec;
        end else if (count_q == CW'(1)) begin
          fin        = 1'b1;
          fin_status = ST_NOTFOUND;
        end else begin
          mem_raddr_o = slot(front_q, cnt_dec[IW-1:0]);
          state_d     = CHK_BACK;
        end
      end
      CHK_BACK: begin
        if (hit) begin
          fin     = 1'b1;
          count_d = cnt_dec;
        end else if (count_q == CW'(2)) begin
          fin        = 1'b1;
          fin_status = ST_NOTFOUND;
        end else begin
          mem_raddr_o = slot(front_q, IW'(1));
          k_d         = IW'(1);
          state_d     = SCAN;
        end
      end
      SCAN: begin
        // compare entry k; its read was issued last cycle
        if (hit) begin
          mem_raddr_o = slot(front_q, k_q + IW'(1));
          state_d     = SHIFT;
        end else if (k_p2 == (CW + 1)'(count_q)) begin
          fin        = 1'b1;
          fin_status = ST_NOTFOUND;
        end else begin
          mem_raddr_o = slot(front_q, k_q + IW'(1));
          k_d         = k_q + IW'(1);
        end
      end
      SHIFT: begin
        // entry k+1 arrives, moves down to k
        mem_we_o    = 1'b1;
        mem_waddr_o = slot(front_q, k_q);
        mem_wdata_o = mem_rdata_i;
        if (k_p2 == (CW + 1)'(count_q)) begin
          fin     = 1'b1;
          count_d = cnt_dec;
        end else begin
          mem_raddr_o = slot(front_q, k_q + IW'(2));
          k_d         = k_q + IW'(1);
        end
      end
      HOLD: begin
        if (res_free_i) begin
          state_d = IDLE;
        end
      end
      default: begin
        state_d = IDLE;
      end
    endcase

    if (fin) begin
      pend_d  = fin_status;
      state_d = res_free_i ? IDLE : HOLD;
    end
  end

  assign cnt_ext = EW'(count_d);

  always_comb begin
    res_o.valid  = fin || (state_q == HOLD);
    res_o.status = fin ? fin_status : pend_q;
    res_o.count  = cnt_ext[CNT_OUT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      front_q <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    k_q    <= k_d;
    pend_q <= pend_d;
  end

endmodule

`default_nettype wire

[dv/blvd_check_pkg.sv]
// Scoreboard class for the bounded list testbench: list predictor plus result checker.
package blvd_check_pkg;
  import blvd_pkg::*;

  localparam int unsigned LIST_DEPTH = 16;

  typedef struct packed {
    status_e              status;
    logic [CNT_OUT_W-1:0] count;
  } outcome_t;

  class list_scoreboard;
    // entries[0] is the front of the list
    logic signed [DATA_W-1:0] entries[$];
    outcome_t                 outcomes[$];
    int unsigned              errors;

    function new();
      errors = 0;
    endfunction

    // Apply one accepted request to the list and queue the status/count it should give.
    function void note_request(logic [REQ_W-1:0] req, logic signed [DATA_W-1:0] value);
      outcome_t exp;
      int       hit;
      int       k;
      exp.status = ST_DONE;
      hit = -1;
      case (req)
        REQ_INS_FRONT: begin
          if (entries.size() >= LIST_DEPTH) exp.status = ST_FULL;
          else entries.push_front(value);
        end
        REQ_INS_BACK: begin
          if (entries.size() >= LIST_DEPTH) exp.status = ST_FULL;
          else entries.push_back(value);
        end
        REQ_REM_FRONT: begin
          if (entries.size() == 0) exp.status = ST_EMPTY;
          else void'(entries.pop_front());
        end
        REQ_REM_BACK: begin
          if (entries.size() == 0) exp.status = ST_EMPTY;
          else void'(entries.pop_back());
        end
        REQ_REM_VALUE: begin
          if (entries.size() == 0) begin
            exp.status = ST_EMPTY;
          end else if (entries[0] == value) begin
            void'(entries.pop_front());
          end else if (entries[entries.size()-1] == value) begin
            void'(entries.pop_back());
          end else begin
            // first match among the middle entries, front to back
            for (k = 1; k + 1 < entries.size(); k++) begin
              if (hit < 0 && entries[k] == value) hit = k;
            end
            if (hit < 0) exp.status = ST_NOTFOUND;
            else entries.delete(hit);
          end
        end
        default: ;
      endcase
      exp.count = CNT_OUT_W'(entries.size());
      outcomes.push_back(exp);
    endfunction

    // Compare one accepted result with the oldest queued outcome.
    function void check_result(logic [1:0] status, logic [CNT_OUT_W-1:0] count,
                               realtime stamp);
      outcome_t exp;
      if (outcomes.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, status %0d count %0d", stamp, status, count);
        return;
      end
      exp = outcomes.pop_front();
      if (status !== exp.status) begin
        errors++;
        $display("%0t ns: status mismatch, expected %0d (%s) actual %0d",
                 stamp, exp.status, exp.status.name(), status);
      end
      if (count !== exp.count) begin
        errors++;
        $display("%0t ns: entry_count mismatch, expected %0d actual %0d",
                 stamp, exp.count, count);
      end
    endfunction
  endclass

endpackage

[dv/bounded_list_with_value_delete_unit_test.sv]
// Self-checking testbench for bounded_list_with_value_delete_unit.
module bounded_list_with_value_delete_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import blvd_pkg::*;
  import blvd_check_pkg::*;

  // Request codes the block does not define; they must leave the list alone.
  localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_C = 3'd7;

  localparam int unsigned RANDOM_ITEMS = 1600;
  // A remove by value can scan and shift the whole list, so the settle wait scales with DEPTH.
  localparam int unsigned SETTLE_CYCLES = 4 * LIST_DEPTH;
  // Worst quiet stretch: long input gap + long output stall + full-length value search.
  localparam int unsigned IDLE_LIMIT = 1000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [REQ_W-1:0]         req_type_i;
  logic signed [DATA_W-1:0] item_value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [1:0]               status_o;
  logic [CNT_OUT_W-1:0]     entry_count_o;

  list_scoreboard           sb = new();
  logic signed [DATA_W-1:0] value_pool[8];
  int unsigned              idle_cycles;

  bounded_list_with_value_delete_unit #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .item_value_i  (item_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle length: half none, most of the rest short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // Drive one request transaction. Inputs move on the falling edge; the
  // handshake is sampled on the rising edge. Valid stays up through stalls
  // and the payload is held until the block takes it.
  task automatic send_request(input logic [REQ_W-1:0] req,
                              input logic signed [DATA_W-1:0] value, input bit calm);
    int unsigned gap;
    bit          taken;
    gap = calm ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    item_value_i <= value;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !in_stall_o;
    end
    sb.note_request(req, value);
  endtask

  // Short directed pass: empty-list removes, unused codes, insert into an
  // empty list from both ends, extreme values, front/back/middle value
  // matches with duplicates present, and a value that is not there.
  task automatic run_directed();
    send_request(REQ_REM_FRONT, 32'sd0, 1'b0);
    send_request(REQ_REM_BACK, 32'sd0, 1'b0);
    send_request(REQ_REM_VALUE, 32'sd5, 1'b0);
    send_request(REQ_SPARE_A, 32'sd0, 1'b0);
    send_request(REQ_SPARE_B, 32'sd0, 1'b0);
    send_request(REQ_SPARE_C, 32'sd0, 1'b0);
    send_request(REQ_INS_FRONT, 32'sh7FFF_FFFF, 1'b0);  // single entry: front and back
    send_request(REQ_REM_VALUE, 32'sh7FFF_FFFF, 1'b0);
    send_request(REQ_INS_BACK, 32'sd42, 1'b0);           // empty list, back side
    send_request(REQ_INS_FRONT, 32'sh8000_0000, 1'b0);
    send_request(REQ_INS_BACK, 32'sh7FFF_FFFF, 1'b0);
    send_request(REQ_INS_FRONT, 32'sd0, 1'b0);
    send_request(REQ_INS_BACK, 32'sd42, 1'b0);
    send_request(REQ_INS_BACK, -32'sd1, 1'b0);
    send_request(REQ_INS_FRONT, 32'sd42, 1'b0);
    send_request(REQ_INS_BACK, 32'sh1234_5678, 1'b0);
    send_request(REQ_REM_VALUE, 32'sd42, 1'b0);          // front match
    send_request(REQ_REM_VALUE, 32'sh1234_5678, 1'b0);   // back match
    send_request(REQ_REM_VALUE, 32'sd42, 1'b0);          // first of two middle matches
    send_request(REQ_REM_VALUE, 32'sd99, 1'b0);          // not present
    send_request(REQ_REM_FRONT, 32'sd0, 1'b0);
    send_request(REQ_REM_BACK, 32'sd0, 1'b0);
  endtask

  // Random request. While filling, inserts dominate so the list reaches
  // full; while draining, removes dominate so it reaches empty. Values mostly
  // come from a small pool (duplicates) or from the live list, so remove by
  // value hits the front, back and middle often.
  task automatic pick_request(input bit draining, output logic [REQ_W-1:0] req,
                              output logic signed [DATA_W-1:0] value);
    int unsigned roll;
    int unsigned insert_pct;
    int unsigned remove_end_pct;
    roll = $urandom_range(0, 99);
    insert_pct = draining ? 18 : 60;
    remove_end_pct = draining ? 50 : 72;
    if (roll < 3) begin
      case ($urandom_range(0, 2))
        0:       req = REQ_SPARE_A;
        1:       req = REQ_SPARE_B;
        default: req = REQ_SPARE_C;
      endcase
    end else if (roll < insert_pct) begin
      req = $urandom_range(0, 1) ? REQ_INS_FRONT : REQ_INS_BACK;
    end else if (roll < remove_end_pct) begin
      req = $urandom_range(0, 1) ? REQ_REM_FRONT : REQ_REM_BACK;
    end else begin
      req = REQ_REM_VALUE;
    end

    if (req == REQ_REM_VALUE && sb.entries.size() != 0 && $urandom_range(0, 99) < 75)
      value = sb.entries[$urandom_range(0, sb.entries.size() - 1)];
    else if ($urandom_range(0, 99) < 80)
      value = value_pool[$urandom_range(0, 7)];
    else
      value = $urandom;

    // keep the pool moving; the two extreme entries stay put
    if ($urandom_range(0, 49) == 0) value_pool[$urandom_range(2, 7)] = $urandom;
  endtask

  // Result sampling on the rising edge: any accepted result goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(status_o, entry_count_o, $realtime);
  end

  // Watchdog: too many cycles without a transaction on either channel is a hang.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Output backpressure: short ready bursts, random stalls, and now and then
  // a long stretch with no stall at all.
  initial begin
    int unsigned span;
    out_stall_i = 1'b0;
    forever begin
      span = ($urandom_range(0, 19) == 0) ? 100 : $urandom_range(1, 6);
      repeat (span) @(negedge clk_i) out_stall_i <= 1'b0;
      span = pick_gap();
      repeat (span) @(negedge clk_i) out_stall_i <= 1'b1;
    end
  end

  // Main sequence
  initial begin
    int unsigned              n;
    int unsigned              k;
    bit                       draining;
    logic [REQ_W-1:0]         req;
    logic signed [DATA_W-1:0] value;

    idle_cycles  = 0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    req_type_i   = REQ_INS_FRONT;
    item_value_i = '0;
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7FFF_FFFF;
    for (k = 2; k < 8; k++) value_pool[k] = $urandom;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();

    draining = 1'b0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // flip direction once the list has sat at an end for a bit
      if (sb.entries.size() == LIST_DEPTH && $urandom_range(0, 2) == 0) draining = 1'b1;
      if (sb.entries.size() == 0 && $urandom_range(0, 2) == 0) draining = 1'b0;
      pick_request(draining, req, value);
      // every fourth block of 128 requests goes back to back
      send_request(req, value, ((n / 128) % 4) == 3);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // wait out the remaining results, then the settle time for strays
    while (sb.outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (sb.errors == 0 && sb.outcomes.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
rtl/blvd_pkg.sv
rtl/blvd_ram.sv
rtl/blvd_ctrl.sv
rtl/bounded_list_with_value_delete_unit.sv
dv/blvd_check_pkg.sv
dv/bounded_list_with_value_delete_unit_test.sv
